// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the gesture recognizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ===== design/tdg_pkg.sv =====
// ----------------------------------------------------------------------------
// Gesture recognizer package
// Codes, widths and shared types of the tap, drag and pinch recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  localparam int THR_W   = 10;
  localparam int WIN_W   = 22;
  localparam int CFG_W   = 22;
  localparam int GEST_W  = 4;
  localparam int RES_MAX = 3;
  localparam int CNT_W   = 2;
  localparam int Q_DEPTH = 2;

  localparam logic [THR_W-1:0] THR_RST = 10'd10;
  localparam logic [WIN_W-1:0] WIN_RST = 22'd300000;

  typedef enum logic [2:0] {
    CMD_DOWN        = 3'd0,
    CMD_MOVE        = 3'd1,
    CMD_UP          = 3'd2,
    CMD_CANCEL      = 3'd3,
    CMD_PINCH_START = 3'd4,
    CMD_PINCH_MOVE  = 3'd5,
    CMD_PINCH_END   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_PENDING    = 2'd1,
    MODE_DRAGGING   = 2'd2,
    MODE_TWO_FINGER = 2'd3
  } mode_t;

  typedef enum logic [GEST_W-1:0] {
    G_DRAG_START   = 4'd0,
    G_DRAG_MOVE    = 4'd1,
    G_DRAG_END     = 4'd2,
    G_DRAG_CANCEL  = 4'd3,
    G_CLICK        = 4'd4,
    G_DOUBLE       = 4'd5,
    G_PINCH_START  = 4'd6,
    G_PINCH_MOVE   = 4'd7,
    G_PINCH_END    = 4'd8,
    G_PINCH_CANCEL = 4'd9
  } gesture_t;

  typedef enum logic [1:0] {
    FS_WAIT = 2'd0,
    FS_SQ   = 2'd1,
    FS_EVAL = 2'd2
  } front_state_t;

  typedef enum logic {
    CFG_DRAG_THR = 1'b0,
    CFG_DBL_WIN  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Width of one packed job: result count plus RES_MAX results.
  function automatic int job_w(input int cb);
    return CNT_W + RES_MAX * (GEST_W + 2 * cb);
  endfunction

endpackage

`default_nettype wire

// ===== design/tap_drag_gesture_recognizer.sv =====
// ----------------------------------------------------------------------------
// Tap, drag and pinch gesture recognizer
// Turns pointer and pinch events into drag, click, double click and pinch
// gestures.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one event per request (cmd, position, timestamp).
//   Output channel out_*: zero to three gestures per event, in order; out_last
//   marks the final gesture of an event. Events with no gesture send nothing.
//   Config port cfg_*: write drag threshold (index 0) or double click window
//   (index 1) while the block is idle; writes take effect at once.
// Timing:
//   An event passes the square-terms state, then the evaluate state, where
//   the next event may be taken. Its gestures pass the job queue and the
//   output register and follow one per cycle while out_stall is low. A
//   2-entry job queue decouples the front end from the output stage.
// Stall:
//   out_stall holds the output register; the front keeps taking events until
//   an event with gestures meets a full queue, then stalls the input.
// Reset:
//   rst_n low clears the gesture state, the queue and the output valid and
//   loads the register defaults (threshold 10, window 300000).
// ----------------------------------------------------------------------------
`default_nettype none

module tap_drag_gesture_recognizer #(
  parameter int COORD_BITS = tdg_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tdg_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_cmd,
  input  wire logic signed [COORD_BITS-1:0]  in_pos_x,
  input  wire logic signed [COORD_BITS-1:0]  in_pos_y,
  input  wire logic [TIME_BITS-1:0]          in_time_us,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tdg_pkg::GEST_W-1:0]         out_gesture,
  output logic signed [COORD_BITS-1:0]       out_x,
  output logic signed [COORD_BITS-1:0]       out_y,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [tdg_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int JOB_W = tdg_pkg::job_w(COORD_BITS);

  tdg_pkg::q_stat_t   q_stat;
  logic               q_push;
  logic               q_pop;
  logic [JOB_W-1:0]   wr_job;
  logic [JOB_W-1:0]   rd_job;

  tdg_front #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_time_us (in_time_us),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_job      (wr_job)
  );

  tdg_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (wr_job),
    .pop     (q_pop),
    .stat    (q_stat),
    .rd_data (rd_job)
  );

  tdg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_job       (rd_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_gesture (out_gesture),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

// ===== design/tdg_queue.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Short FIFO of classified jobs between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tdg_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              pop,
  output tdg_pkg::q_stat_t       stat,
  output logic      [DATA_W-1:0] rd_data
);

  localparam int PTR_W = (tdg_pkg::Q_DEPTH > 1) ? $clog2(tdg_pkg::Q_DEPTH) : 1;
  localparam int CQ_W  = $clog2(tdg_pkg::Q_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [tdg_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CQ_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tdg_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tdg_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign stat.full  = (count_r == CQ_W'(tdg_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && stat.full, "job queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && stat.empty, "job queue underflow")

endmodule

`default_nettype wire

// ===== design/tdg_front.sv =====
// ----------------------------------------------------------------------------
// Gesture front end
// Accepts events, keeps the gesture state and turns each event into a job
// of up to three results for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tdg_front #(
  parameter int COORD_BITS = tdg_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tdg_pkg::TIME_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  output logic                                             in_stall,
  input  wire logic [2:0]                                  in_cmd,
  input  wire logic signed [COORD_BITS-1:0]                in_pos_x,
  input  wire logic signed [COORD_BITS-1:0]                in_pos_y,
  input  wire logic [TIME_BITS-1:0]                        in_time_us,
  input  wire logic                                        cfg_we,
  input  wire logic                                        cfg_index,
  input  wire logic [tdg_pkg::CFG_W-1:0]                   cfg_wdata,
  input  tdg_pkg::q_stat_t                                 q_stat,
  output logic                                             q_push,
  output logic [tdg_pkg::job_w(COORD_BITS)-1:0]            q_job
);

  localparam int CB   = COORD_BITS;
  localparam int SQ_W = 2 * (CB + 1);
  localparam int DW   = (SQ_W + 1 > 2 * tdg_pkg::THR_W) ? SQ_W + 1 : 2 * tdg_pkg::THR_W;
  localparam int EW   = (TIME_BITS > tdg_pkg::WIN_W) ? TIME_BITS : tdg_pkg::WIN_W;

  typedef struct packed {
    tdg_pkg::gesture_t gesture;
    logic [CB-1:0]     x;
    logic [CB-1:0]     y;
  } res_t;

  typedef struct packed {
    logic [tdg_pkg::CNT_W-1:0]       cnt;
    res_t [tdg_pkg::RES_MAX-1:0]     res;
  } job_t;

  function automatic res_t mk_res(input tdg_pkg::gesture_t g, input logic [CB-1:0] x,
                                  input logic [CB-1:0] y);
    res_t r;
    r.gesture = g;
    r.x       = x;
    r.y       = y;
    return r;
  endfunction

  tdg_pkg::front_state_t state_r, state_nxt;

  // configuration
  logic [tdg_pkg::THR_W-1:0] thr_r;
  logic [tdg_pkg::WIN_W-1:0] win_r;

  // event held for evaluation
  logic [2:0]              cmd_r;
  logic signed [CB-1:0]    x_r, y_r;
  logic [TIME_BITS-1:0]    t_r;

  // distance terms
  logic [SQ_W-1:0]             sq_x_r, sq_y_r;
  logic [2*tdg_pkg::THR_W-1:0] thr_sq_r;
  logic                        win_ok_r;

  // gesture state
  tdg_pkg::mode_t       mode_r, mode_nxt;
  logic                 pinch_r, pinch_nxt;
  logic                 supp_r, supp_nxt;
  logic [CB-1:0]        start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [CB-1:0]        track_x_r, track_x_nxt, track_y_r, track_y_nxt;
  logic                 cvalid_r, cvalid_nxt;
  logic [TIME_BITS-1:0] ctime_r, ctime_nxt;
  logic [CB-1:0]        click_x_r, click_x_nxt, click_y_r, click_y_nxt;

  logic                 accept;
  logic                 adv;
  logic                 do_cancel;
  logic [1:0]           n;
  job_t                 job;

  // square stage
  logic [CB-1:0]             ref_x, ref_y;
  logic signed [CB:0]        dx, dy;
  logic signed [SQ_W-1:0]    sq_x, sq_y;
  logic [2*tdg_pkg::THR_W-1:0] thr_sq;
  logic [TIME_BITS-1:0]      elapsed;
  logic [EW-1:0]             el_ext, win_ext;

  // evaluation stage
  logic [DW-1:0]             dsum, thr_ext;
  logic                      far, near;

  assign accept = in_valid && !in_stall;

  // Up compares against the last click, everything else against the start.
  assign ref_x   = (cmd_r == tdg_pkg::CMD_UP) ? click_x_r : start_x_r;
  assign ref_y   = (cmd_r == tdg_pkg::CMD_UP) ? click_y_r : start_y_r;
  assign dx      = {x_r[CB-1], x_r} - {ref_x[CB-1], ref_x};
  assign dy      = {y_r[CB-1], y_r} - {ref_y[CB-1], ref_y};
  assign sq_x    = dx * dx;
  assign sq_y    = dy * dy;
  assign thr_sq  = thr_r * thr_r;
  assign elapsed = t_r - ctime_r;
  assign el_ext  = EW'(elapsed);
  assign win_ext = EW'(win_r);

  assign dsum    = DW'(sq_x_r) + DW'(sq_y_r);
  assign thr_ext = DW'(thr_sq_r);
  assign far     = (dsum >= thr_ext);
  assign near    = (dsum <= thr_ext);

  always_comb begin
    job         = '0;
    n           = '0;
    mode_nxt    = mode_r;
    pinch_nxt   = pinch_r;
    supp_nxt    = supp_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    track_x_nxt = track_x_r;
    track_y_nxt = track_y_r;
    cvalid_nxt  = cvalid_r;
    ctime_nxt   = ctime_r;
    click_x_nxt = click_x_r;
    click_y_nxt = click_y_r;

    do_cancel = (cmd_r inside {tdg_pkg::CMD_DOWN, tdg_pkg::CMD_CANCEL,
                               tdg_pkg::CMD_PINCH_START});
    if (do_cancel) begin
      if (mode_r == tdg_pkg::MODE_DRAGGING) begin
        job.res[n] = mk_res(tdg_pkg::G_DRAG_CANCEL, track_x_r, track_y_r);
        n = n + 1'b1;
      end
      if (pinch_r) begin
        job.res[n] = mk_res(tdg_pkg::G_PINCH_CANCEL, '0, '0);
        n = n + 1'b1;
      end
      mode_nxt  = tdg_pkg::MODE_IDLE;
      pinch_nxt = 1'b0;
      supp_nxt  = 1'b1;
    end

    unique case (cmd_r)
      tdg_pkg::CMD_DOWN: begin
        mode_nxt    = tdg_pkg::MODE_PENDING;
        supp_nxt    = 1'b0;
        start_x_nxt = x_r;
        start_y_nxt = y_r;
        track_x_nxt = x_r;
        track_y_nxt = y_r;
      end
      tdg_pkg::CMD_MOVE: begin
        if (mode_r == tdg_pkg::MODE_PENDING && far) begin
          mode_nxt   = tdg_pkg::MODE_DRAGGING;
          job.res[n] = mk_res(tdg_pkg::G_DRAG_START, start_x_r, start_y_r);
          n          = n + 1'b1;
        end
        if (mode_nxt == tdg_pkg::MODE_DRAGGING) begin
          job.res[n]  = mk_res(tdg_pkg::G_DRAG_MOVE, x_r, y_r);
          n           = n + 1'b1;
          track_x_nxt = x_r;
          track_y_nxt = y_r;
        end
      end
      tdg_pkg::CMD_UP: begin
        mode_nxt = tdg_pkg::MODE_IDLE;
        if (mode_r == tdg_pkg::MODE_DRAGGING) begin
          job.res[n] = mk_res(tdg_pkg::G_DRAG_END, x_r, y_r);
          n          = n + 1'b1;
          supp_nxt   = 1'b1;
        end else if (mode_r == tdg_pkg::MODE_PENDING) begin
          if (supp_r) begin
            supp_nxt = 1'b0;
          end else if (cvalid_r && win_ok_r && near) begin
            // consume the click so a third tap starts over
            cvalid_nxt = 1'b0;
            job.res[n] = mk_res(tdg_pkg::G_DOUBLE, x_r, y_r);
            n          = n + 1'b1;
          end else begin
            cvalid_nxt  = 1'b1;
            ctime_nxt   = t_r;
            click_x_nxt = x_r;
            click_y_nxt = y_r;
            job.res[n]  = mk_res(tdg_pkg::G_CLICK, x_r, y_r);
            n           = n + 1'b1;
          end
        end
      end
      tdg_pkg::CMD_CANCEL: begin
      end
      tdg_pkg::CMD_PINCH_START: begin
        mode_nxt   = tdg_pkg::MODE_TWO_FINGER;
        pinch_nxt  = 1'b1;
        supp_nxt   = 1'b1;
        job.res[n] = mk_res(tdg_pkg::G_PINCH_START, x_r, y_r);
        n          = n + 1'b1;
      end
      tdg_pkg::CMD_PINCH_MOVE: begin
        if (!pinch_r) begin
          // open a session first; any drag is dropped silently
          mode_nxt   = tdg_pkg::MODE_TWO_FINGER;
          pinch_nxt  = 1'b1;
          supp_nxt   = 1'b1;
          job.res[n] = mk_res(tdg_pkg::G_PINCH_START, x_r, y_r);
          n          = n + 1'b1;
        end
        job.res[n] = mk_res(tdg_pkg::G_PINCH_MOVE, x_r, y_r);
        n          = n + 1'b1;
      end
      tdg_pkg::CMD_PINCH_END: begin
        if (pinch_r) begin
          job.res[n] = mk_res(tdg_pkg::G_PINCH_END, x_r, y_r);
          n          = n + 1'b1;
        end
        mode_nxt  = tdg_pkg::MODE_IDLE;
        pinch_nxt = 1'b0;
        supp_nxt  = 1'b1;
      end
      default: begin
      end
    endcase

    job.cnt = n;
  end

  // Events without results never wait for queue space.
  assign adv = (n == '0) || !q_stat.full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdg_pkg::FS_WAIT: state_nxt = accept ? tdg_pkg::FS_SQ : tdg_pkg::FS_WAIT;
      tdg_pkg::FS_SQ:   state_nxt = tdg_pkg::FS_EVAL;
      tdg_pkg::FS_EVAL: begin
        if (adv) begin
          state_nxt = accept ? tdg_pkg::FS_SQ : tdg_pkg::FS_WAIT;
        end
      end
      default: state_nxt = tdg_pkg::FS_WAIT;
    endcase
  end

  always_comb begin
    in_stall = 1'b0;
    q_push   = 1'b0;
    unique case (state_r)
      tdg_pkg::FS_WAIT: in_stall = 1'b0;
      tdg_pkg::FS_SQ:   in_stall = 1'b1;
      tdg_pkg::FS_EVAL: begin
        in_stall = !adv;
        q_push   = (n != '0) && !q_stat.full;
      end
      default: in_stall = 1'b1;
    endcase
  end

  assign q_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tdg_pkg::FS_WAIT;
      thr_r     <= tdg_pkg::THR_RST;
      win_r     <= tdg_pkg::WIN_RST;
      mode_r    <= tdg_pkg::MODE_IDLE;
      pinch_r   <= 1'b0;
      supp_r    <= 1'b0;
      start_x_r <= '0;
      start_y_r <= '0;
      track_x_r <= '0;
      track_y_r <= '0;
      cvalid_r  <= 1'b0;
      ctime_r   <= '0;
      click_x_r <= '0;
      click_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == tdg_pkg::CFG_DRAG_THR) begin
          thr_r <= cfg_wdata[tdg_pkg::THR_W-1:0];
        end else begin
          win_r <= cfg_wdata[tdg_pkg::WIN_W-1:0];
        end
      end
      if (state_r == tdg_pkg::FS_EVAL && adv) begin
        mode_r    <= mode_nxt;
        pinch_r   <= pinch_nxt;
        supp_r    <= supp_nxt;
        start_x_r <= start_x_nxt;
        start_y_r <= start_y_nxt;
        track_x_r <= track_x_nxt;
        track_y_r <= track_y_nxt;
        cvalid_r  <= cvalid_nxt;
        ctime_r   <= ctime_nxt;
        click_x_r <= click_x_nxt;
        click_y_r <= click_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
      t_r   <= in_time_us;
    end
    if (state_r == tdg_pkg::FS_SQ) begin
      sq_x_r   <= sq_x;
      sq_y_r   <= sq_y;
      thr_sq_r <= thr_sq;
      win_ok_r <= (el_ext <= win_ext);
    end
  end

  `ASSERT_CLK(a_accept_to_sq, clk, rst_n, accept |=> (state_r == tdg_pkg::FS_SQ),
              "accepted event did not enter the square stage")

endmodule

`default_nettype wire

// ===== design/tdg_back.sv =====
// ----------------------------------------------------------------------------
// Gesture back end
// Unpacks queued jobs and delivers their results one per cycle, while
// out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tdg_back #(
  parameter int COORD_BITS = tdg_pkg::COORD_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  tdg_pkg::q_stat_t                            q_stat,
  input  wire logic [tdg_pkg::job_w(COORD_BITS)-1:0]  q_job,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [tdg_pkg::GEST_W-1:0]                  out_gesture,
  output logic signed [COORD_BITS-1:0]                out_x,
  output logic signed [COORD_BITS-1:0]                out_y,
  output logic                                        out_last
);

  localparam int CB = COORD_BITS;

  typedef struct packed {
    tdg_pkg::gesture_t gesture;
    logic [CB-1:0]     x;
    logic [CB-1:0]     y;
  } res_t;

  typedef struct packed {
    logic [tdg_pkg::CNT_W-1:0]   cnt;
    res_t [tdg_pkg::RES_MAX-1:0] res;
  } job_t;

  job_t                      job;
  res_t                      cur;
  logic [1:0]                idx_r, idx_nxt;
  logic                      load;
  logic                      is_last;
  logic                      out_valid_r;
  logic [tdg_pkg::GEST_W-1:0] gest_r;
  logic [CB-1:0]             x_r, y_r;
  logic                      last_r;

  assign job     = q_job;
  assign cur     = job.res[idx_r];
  assign is_last = (idx_r == job.cnt - 1'b1);
  assign load    = !q_stat.empty && (!out_valid_r || !out_stall);
  assign q_pop   = load && is_last;
  assign idx_nxt = (load && is_last) ? '0 : (load ? idx_r + 1'b1 : idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gest_r <= cur.gesture;
      x_r    <= cur.x;
      y_r    <= cur.y;
      last_r <= is_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_gesture = gest_r;
  assign out_x       = x_r;
  assign out_y       = y_r;
  assign out_last    = last_r;

  `ASSERT_CLK(a_pop_marks_last, clk, rst_n, q_pop |=> (out_valid_r && last_r),
              "job retired without a final result")
  `ASSERT_CLK(a_idx_in_job, clk, rst_n, !q_stat.empty |-> (idx_r < job.cnt),
              "result index past the end of the job")

endmodule

`default_nettype wire

// ===== dv/tb_tap_drag_gesture_recognizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gesture recognizer testbench
// Drives pointer and pinch events into the recognizer and checks every
// gesture against a script row or an in-bench tap, drag and pinch predictor.
// A directed script covers the boundaries, then taps, drags, pinches and
// noise run under four register settings and three idle patterns.
// ----------------------------------------------------------------------------

module tb_tap_drag_gesture_recognizer;

  localparam int CW = tdg_pkg::COORD_BITS_DEF;
  localparam int TW = tdg_pkg::TIME_BITS_DEF;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_EVENTS = 35;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MAX = 16'sh7FFF;
  localparam coord_t C_MIN = 16'sh8000;

  typedef struct {
    tdg_pkg::gesture_t g;
    coord_t            x;
    coord_t            y;
    logic              is_last;
  } gest_t;

  typedef struct {
    logic [2:0]        cmd;
    coord_t            x;
    coord_t            y;
    logic [TW-1:0]     t;
    bit                typed;
    tdg_pkg::gesture_t g;
    coord_t            gx;
    coord_t            gy;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [2:0]                 in_cmd = '0;
  coord_t                     in_pos_x = '0;
  coord_t                     in_pos_y = '0;
  logic [TW-1:0]              in_time_us = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [tdg_pkg::GEST_W-1:0] out_gesture;
  coord_t                     out_x;
  coord_t                     out_y;
  logic                       out_last;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [tdg_pkg::CFG_W-1:0]  cfg_wdata = '0;

  tap_drag_gesture_recognizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_time_us (in_time_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_gesture(out_gesture),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor copy of the recognizer state and registers.
  logic [tdg_pkg::THR_W-1:0] drag_thr = tdg_pkg::THR_RST;
  logic [tdg_pkg::WIN_W-1:0] dbl_window = tdg_pkg::WIN_RST;
  tdg_pkg::mode_t            touch_mode = tdg_pkg::MODE_IDLE;
  logic                      two_finger_on = 1'b0;
  logic                      hold_click = 1'b0;
  coord_t                    anchor_x = '0;
  coord_t                    anchor_y = '0;
  coord_t                    trail_x = '0;
  coord_t                    trail_y = '0;
  logic                      tap_seen = 1'b0;
  logic [TW-1:0]             tap_time = '0;
  coord_t                    tap_x = '0;
  coord_t                    tap_y = '0;

  gest_t event_gestures[$];
  gest_t due_gestures[$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int events_sent = 0;
  int gestures_checked = 0;
  int kind_seen [10];
  int quiet_cycles = 0;

  // Stimulus state for the random sequences.
  logic [TW-1:0] now_us;
  coord_t        spot_x;
  coord_t        spot_y;

  row_t script [27] = '{
    '{tdg_pkg::CMD_DOWN,        16'sd0,   16'sd0,   32'd0,         1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd0,   16'sd0,   32'd100,       1'b1,
      tdg_pkg::G_CLICK,         16'sd0,   16'sd0},
    '{tdg_pkg::CMD_DOWN,        16'sd3,   16'sd4,   32'd200,       1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd3,   16'sd4,   32'd300,       1'b1,
      tdg_pkg::G_DOUBLE,        16'sd3,   16'sd4},
    '{tdg_pkg::CMD_DOWN,        16'sd0,   16'sd0,   32'd1000,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd0,   16'sd0,   32'd2000,      1'b1,
      tdg_pkg::G_CLICK,         16'sd0,   16'sd0},
    // timestamp runs backwards: huge elapsed time, plain click
    '{tdg_pkg::CMD_DOWN,        16'sd0,   16'sd0,   32'd1900,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd0,   16'sd0,   32'd1900,      1'b1,
      tdg_pkg::G_CLICK,         16'sd0,   16'sd0},
    '{tdg_pkg::CMD_DOWN,        C_MAX,    C_MIN,    32'd3000,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_MOVE,        C_MAX,    C_MIN,    32'd3100,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_MOVE,        C_MIN,    C_MAX,    32'd3200,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd7,   16'sd7,   32'd3400,      1'b1,
      tdg_pkg::G_DRAG_END,      16'sd7,   16'sd7},
    '{tdg_pkg::CMD_DOWN,        16'sd0,   16'sd0,   32'd4000,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    // move of exactly the threshold distance starts a drag
    '{tdg_pkg::CMD_MOVE,        16'sd6,   16'sd8,   32'd4100,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_DOWN,        16'sd1,   16'sd1,   32'd4200,      1'b1,
      tdg_pkg::G_DRAG_CANCEL,   16'sd6,   16'sd8},
    '{tdg_pkg::CMD_CANCEL,      16'sd0,   16'sd0,   32'd4300,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd2,   16'sd2,   32'd4350,      1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_PINCH_START, 16'sd5,   16'sd6,   32'd4400,      1'b1,
      tdg_pkg::G_PINCH_START,   16'sd5,   16'sd6},
    '{tdg_pkg::CMD_PINCH_MOVE,  C_MIN,    C_MIN,    32'd4500,      1'b1,
      tdg_pkg::G_PINCH_MOVE,    C_MIN,    C_MIN},
    '{tdg_pkg::CMD_PINCH_END,   C_MAX,    C_MAX,    32'd4600,      1'b1,
      tdg_pkg::G_PINCH_END,     C_MAX,    C_MAX},
    // pinch move with no session opens one first
    '{tdg_pkg::CMD_PINCH_MOVE,  16'sd100, -16'sd100, 32'd4700,     1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_CANCEL,      16'sd9,   16'sd9,   32'd4800,      1'b1,
      tdg_pkg::G_PINCH_CANCEL,  16'sd0,   16'sd0},
    '{tdg_pkg::CMD_DOWN,        16'sd20,  16'sd20,  32'hFFFF_FF00, 1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd20,  16'sd20,  32'hFFFF_FF00, 1'b1,
      tdg_pkg::G_CLICK,         16'sd20,  16'sd20},
    // timestamp wraps past zero, still inside the window
    '{tdg_pkg::CMD_DOWN,        16'sd20,  16'sd30,  32'h0000_0010, 1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0},
    '{tdg_pkg::CMD_UP,          16'sd20,  16'sd30,  32'h0000_0010, 1'b1,
      tdg_pkg::G_DOUBLE,        16'sd20,  16'sd30},
    '{CMD_UNUSED,               16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF, 1'b0,
      tdg_pkg::G_DRAG_START,    16'sd0,   16'sd0}
  };

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic longint sq_dist(input coord_t ax, input coord_t ay,
                                     input coord_t bx, input coord_t by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic void push_gesture(input tdg_pkg::gesture_t g, input coord_t x,
                                       input coord_t y);
    gest_t e;
    e.g = g;
    e.x = x;
    e.y = y;
    e.is_last = 1'b0;
    if (event_gestures.size() < tdg_pkg::RES_MAX) event_gestures.push_back(e);
  endfunction

  function automatic void drop_active();
    if (touch_mode == tdg_pkg::MODE_DRAGGING)
      push_gesture(tdg_pkg::G_DRAG_CANCEL, trail_x, trail_y);
    if (two_finger_on) push_gesture(tdg_pkg::G_PINCH_CANCEL, '0, '0);
    touch_mode = tdg_pkg::MODE_IDLE;
    two_finger_on = 1'b0;
    hold_click = 1'b1;
  endfunction

  function automatic void begin_pinch(input coord_t x, input coord_t y);
    touch_mode = tdg_pkg::MODE_TWO_FINGER;
    two_finger_on = 1'b1;
    hold_click = 1'b1;
    push_gesture(tdg_pkg::G_PINCH_START, x, y);
  endfunction

  // Work out the gestures one event causes and advance the predicted state.
  function automatic void recognize_event(input logic [2:0] cmd, input coord_t x,
                                          input coord_t y, input logic [TW-1:0] t);
    longint        thr_sq;
    logic [TW-1:0] elapsed;
    event_gestures.delete();
    thr_sq = longint'(drag_thr) * longint'(drag_thr);
    case (cmd)
      tdg_pkg::CMD_DOWN: begin
        drop_active();
        touch_mode = tdg_pkg::MODE_PENDING;
        hold_click = 1'b0;
        anchor_x = x;
        anchor_y = y;
        trail_x = x;
        trail_y = y;
      end
      tdg_pkg::CMD_MOVE: begin
        if (touch_mode == tdg_pkg::MODE_PENDING &&
            sq_dist(x, y, anchor_x, anchor_y) >= thr_sq) begin
          touch_mode = tdg_pkg::MODE_DRAGGING;
          push_gesture(tdg_pkg::G_DRAG_START, anchor_x, anchor_y);
        end
        if (touch_mode == tdg_pkg::MODE_DRAGGING) begin
          push_gesture(tdg_pkg::G_DRAG_MOVE, x, y);
          trail_x = x;
          trail_y = y;
        end
      end
      tdg_pkg::CMD_UP: begin
        if (touch_mode == tdg_pkg::MODE_DRAGGING) begin
          push_gesture(tdg_pkg::G_DRAG_END, x, y);
          touch_mode = tdg_pkg::MODE_IDLE;
          hold_click = 1'b1;
        end else if (touch_mode != tdg_pkg::MODE_PENDING) begin
          touch_mode = tdg_pkg::MODE_IDLE;
        end else begin
          touch_mode = tdg_pkg::MODE_IDLE;
          if (hold_click) begin
            hold_click = 1'b0;
          end else begin
            elapsed = t - tap_time;
            if (tap_seen && elapsed <= TW'(dbl_window) &&
                sq_dist(x, y, tap_x, tap_y) <= thr_sq) begin
              tap_seen = 1'b0;
              push_gesture(tdg_pkg::G_DOUBLE, x, y);
            end else begin
              tap_seen = 1'b1;
              tap_time = t;
              tap_x = x;
              tap_y = y;
              push_gesture(tdg_pkg::G_CLICK, x, y);
            end
          end
        end
      end
      tdg_pkg::CMD_CANCEL: drop_active();
      tdg_pkg::CMD_PINCH_START: begin
        drop_active();
        begin_pinch(x, y);
      end
      tdg_pkg::CMD_PINCH_MOVE: begin
        if (!two_finger_on) begin_pinch(x, y);
        push_gesture(tdg_pkg::G_PINCH_MOVE, x, y);
      end
      tdg_pkg::CMD_PINCH_END: begin
        if (two_finger_on) push_gesture(tdg_pkg::G_PINCH_END, x, y);
        touch_mode = tdg_pkg::MODE_IDLE;
        two_finger_on = 1'b0;
        hold_click = 1'b1;
      end
      default: ;
    endcase
    if (event_gestures.size() > 0) event_gestures[event_gestures.size() - 1].is_last = 1'b1;
  endfunction

  // Present one request, hold it until taken, then queue what it should cause.
  task automatic offer_event(input row_t r);
    gest_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_pos_x <= r.x;
    in_pos_y <= r.y;
    in_time_us <= r.t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    recognize_event(r.cmd, r.x, r.y, r.t);
    if (r.typed) begin
      e.g = r.g;
      e.x = r.gx;
      e.y = r.gy;
      e.is_last = 1'b1;
      due_gestures.push_back(e);
    end else begin
      foreach (event_gestures[i]) due_gestures.push_back(event_gestures[i]);
    end
    if (r.cmd != CMD_UNUSED) events_sent++;
  endtask

  task automatic post(input logic [2:0] cmd, input coord_t x, input coord_t y,
                      input logic [TW-1:0] t);
    row_t r;
    r.cmd = cmd;
    r.x = x;
    r.y = y;
    r.t = t;
    r.typed = 1'b0;
    r.g = tdg_pkg::G_DRAG_START;
    r.gx = '0;
    r.gy = '0;
    offer_event(r);
  endtask

  // Drop valid and hold off until every queued gesture is out.
  task automatic wait_quiet(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_gestures.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic load_settings(input logic [tdg_pkg::THR_W-1:0] thr,
                               input logic [tdg_pkg::WIN_W-1:0] win);
    cfg_we <= 1'b1;
    cfg_index <= tdg_pkg::CFG_DRAG_THR;
    cfg_wdata <= tdg_pkg::CFG_W'(thr);
    @(posedge clk);
    drag_thr = thr;
    cfg_index <= tdg_pkg::CFG_DBL_WIN;
    cfg_wdata <= tdg_pkg::CFG_W'(win);
    @(posedge clk);
    dbl_window = win;
    cfg_we <= 1'b0;
  endtask

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [TW-1:0] time_step();
    return ($urandom_range(3) == 0) ? '0 : TW'($urandom_range(1, 200000));
  endfunction

  task automatic tap_seq();
    coord_t x, y;
    if ($urandom_range(2) != 0) begin
      x = spot_x + coord_t'(jitter(int'(drag_thr)));
      y = spot_y + coord_t'(jitter(int'(drag_thr)));
    end else begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
    end
    now_us = now_us + time_step();
    post(tdg_pkg::CMD_DOWN, x, y, now_us);
    if ($urandom_range(3) == 0)
      post(tdg_pkg::CMD_MOVE, x + coord_t'(jitter(int'(drag_thr) / 2)),
           y + coord_t'(jitter(int'(drag_thr) / 2)), now_us);
    now_us = now_us + time_step();
    post(tdg_pkg::CMD_UP, x, y, now_us);
    spot_x = x;
    spot_y = y;
  endtask

  task automatic drag_seq();
    coord_t x, y;
    x = coord_t'($urandom);
    y = coord_t'($urandom);
    now_us = now_us + time_step();
    post(tdg_pkg::CMD_DOWN, x, y, now_us);
    repeat ($urandom_range(1, 5)) begin
      x = x + coord_t'(jitter(int'(drag_thr) + 4));
      y = y + coord_t'(jitter(int'(drag_thr) + 4));
      now_us = now_us + TW'($urandom_range(0, 20000));
      post(tdg_pkg::CMD_MOVE, x, y, now_us);
    end
    case ($urandom_range(5))
      0: post(tdg_pkg::CMD_CANCEL, x, y, now_us);
      1: post(tdg_pkg::CMD_DOWN, x, y, now_us);
      2: post(tdg_pkg::CMD_PINCH_START, x, y, now_us);
      default: post(tdg_pkg::CMD_UP, x, y, now_us);
    endcase
  endtask

  task automatic pinch_seq();
    coord_t x, y;
    x = coord_t'($urandom);
    y = coord_t'($urandom);
    post($urandom_range(1) ? tdg_pkg::CMD_PINCH_START : tdg_pkg::CMD_PINCH_MOVE,
         x, y, now_us);
    repeat ($urandom_range(0, 4)) begin
      x = x + coord_t'(jitter(64));
      y = y + coord_t'(jitter(64));
      post(tdg_pkg::CMD_PINCH_MOVE, x, y, now_us);
    end
    case ($urandom_range(4))
      0: post(tdg_pkg::CMD_CANCEL, x, y, now_us);
      1: post(tdg_pkg::CMD_DOWN, x, y, now_us);
      2: post(tdg_pkg::CMD_UP, x, y, now_us);
      default: post(tdg_pkg::CMD_PINCH_END, x, y, now_us);
    endcase
  endtask

  task automatic noise_seq();
    repeat ($urandom_range(1, 3))
      post(3'($urandom_range(7)), coord_t'($urandom), coord_t'($urandom),
           $urandom_range(1) ? TW'($urandom) : now_us);
  endtask

  // Gesture checker and receiver-side stall.
  always @(posedge clk) begin
    gest_t e;
    if (rst_n && out_valid && !out_stall) begin
      gestures_checked++;
      if (due_gestures.size() == 0) begin
        flag_error($sformatf("unexpected gesture %0d at (%0d,%0d) last %0d",
                             out_gesture, out_x, out_y, out_last));
      end else begin
        e = due_gestures.pop_front();
        kind_seen[int'(e.g)]++;
        if (out_gesture !== e.g || out_x !== e.x || out_y !== e.y || out_last !== e.is_last)
          flag_error($sformatf("gesture exp %0d (%0d,%0d) last %0d, got %0d (%0d,%0d) last %0d",
                               e.g, e.x, e.y, e.is_last, out_gesture, out_x, out_y,
                               out_last));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: end the run when neither side moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
      $display("tap_drag_gesture_recognizer regression: fail");
      $finish;
    end
  end

  initial begin
    int goal;
    int seq_no;
    int kind;
    send_idle_pct = 25;
    recv_idle_pct = 72;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) offer_event(script[i]);

    now_us = $urandom;
    spot_x = coord_t'($urandom);
    spot_y = coord_t'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet(8);
      case (ph)
        0: load_settings('0, '0);
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 25;
          load_settings('1, '1);
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          load_settings(tdg_pkg::THR_W'($urandom_range(1, 40)),
                        tdg_pkg::WIN_W'($urandom_range(1000, 600000)));
        end
        default: load_settings(tdg_pkg::THR_W'($urandom_range(1023)),
                               tdg_pkg::WIN_W'($urandom_range(4194303)));
      endcase
      goal = events_sent + PHASE_EVENTS;
      seq_no = 0;
      while (events_sent < goal) begin
        kind = $urandom_range(9);
        if (kind < 4) tap_seq();
        else if (kind < 6) drag_seq();
        else if (kind < 8) pinch_seq();
        else noise_seq();
        seq_no++;
        // hold the sender back until the output side has caught up
        if (seq_no % 12 == 5) wait_quiet(0);
      end
    end

    wait_quiet(12);
    if (due_gestures.size() != 0)
      flag_error($sformatf("%0d gestures never arrived", due_gestures.size()));
    $display("covered %0d events and %0d gestures under five register settings",
             events_sent, gestures_checked);
    $display("seen: %0d clicks, %0d doubles, %0d drag starts, %0d pinch starts, %0d errors",
             kind_seen[tdg_pkg::G_CLICK], kind_seen[tdg_pkg::G_DOUBLE],
             kind_seen[tdg_pkg::G_DRAG_START], kind_seen[tdg_pkg::G_PINCH_START], errors);
    if (errors == 0) begin
      $display("tap_drag_gesture_recognizer regression: pass");
    end else begin
      $display("tap_drag_gesture_recognizer regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/tdg_pkg.sv
design/tdg_queue.sv
design/tdg_front.sv
design/tdg_back.sv
design/tap_drag_gesture_recognizer.sv
dv/tb_tap_drag_gesture_recognizer.sv
